// ===== sv/rsm_pkg.sv =====
// Shared types and constants for the rANS symbol mapper with bypass escape.
// Used by rsm_shifter and rans_symbol_mapper_with_bypass_core; no dependencies.
`default_nettype none

package rsm_pkg;

   // Table sizes and the width of a bypass value.
   localparam int MAX_DISTRIBUTIONS = 64;
   localparam int MAX_SYMBOLS       = 4096;
   localparam int FREQ_WIDTH        = 32;

   // Address and shift widths derived from the sizes above.
   localparam int DESC_AW  = $clog2(MAX_DISTRIBUTIONS);
   localparam int SYM_AW   = $clog2(MAX_SYMBOLS);
   localparam int SHAMT_W  = $clog2(FREQ_WIDTH);
   localparam int POS_W    = SHAMT_W + 1;

   // Fixed field widths.
   localparam int DIGIT_W  = 16;
   localparam int BITS_W   = 5;
   localparam int DESC_W   = 40;
   localparam int SYM_W    = 33;

   // Request actions.
   localparam logic [1:0] ACT_LOAD_DESC = 2'd0;
   localparam logic [1:0] ACT_LOAD_SYM  = 2'd1;
   localparam logic [1:0] ACT_ENCODE    = 2'd2;

   // Control register indexes.
   localparam logic [1:0] CSR_SYMBOL_BITS = 2'd0;
   localparam logic [1:0] CSR_BYPASS_BITS = 2'd1;
   localparam logic [1:0] CSR_NUM_DIST    = 2'd2;

   // Sequencer states.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CALC,
      ST_CHECK,
      ST_COUNT,
      ST_DIGIT,
      ST_REM,
      ST_PREFIX,
      ST_SYM
   } state_type;

   // Operands for the shared shift unit.
   typedef struct packed {
      logic [FREQ_WIDTH-1:0] data;
      logic [SHAMT_W-1:0]    amount;
      logic [DIGIT_W-1:0]    mask;
   } shift_req_type;

endpackage

`default_nettype wire

// ===== sv/rsm_shifter.sv =====
// Shared right shifter and digit mask of the bypass path.
// Depends on rsm_pkg for the operand struct and widths.
`default_nettype none

module rsm_shifter import rsm_pkg::*; (
   input  shift_req_type          shift_req,
   output logic [FREQ_WIDTH-1:0]  shift_result,
   output logic [DIGIT_W-1:0]     shift_digit
);

   // Shift the bypass value down and keep the low digit.
   always_comb begin
      shift_result = shift_req.data >> shift_req.amount;
      shift_digit  = shift_result[DIGIT_W-1:0] & shift_req.mask;
   end

endmodule

`default_nettype wire

// ===== sv/rans_symbol_mapper_with_bypass_core.sv =====
// Top level of the rANS symbol mapper with bypass escape: sequencer, tables, registers.
// Depends on rsm_pkg and instantiates rsm_shifter.
`default_nettype none

// Usage
// A request is taken on a rising edge where start is high and busy is low. Action 0
// writes a descriptor, action 1 a symbol table entry; both complete at that edge and
// busy stays low. Action 2 encodes req_value in distribution req_dist_index; a
// negative index is taken and dropped. An encode raises busy until its last put.
// Puts appear on the rsp_ ports for one cycle each, marked by rsp_valid; rsp_last
// flags the final put of a request. The receiver cannot stall, so puts leave one
// per cycle with no back-pressure.
// An in-range value passes through the calc and check states and gives its single
// put in the symbol state; the next request is taken once the block is idle again.
// An escaped value puts its bypass digits, the remainder and its prefix entries before
// the symbol; the count loop and the digit loop share one shifter, one digit a cycle.
// The table lookups each cost one registered memory read.
// Reset returns the sequencer to idle and the control registers to their defaults
// (symbol_bits 16, bypass_bits 2, num_distributions 1). The tables keep whatever
// they hold and must be loaded before use.

module rans_symbol_mapper_with_bypass_core import rsm_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   // Request channel
   input  logic                start,
   output logic                busy,
   input  logic [1:0]          req_action,
   input  logic signed [6:0]   req_dist_index,
   input  logic signed [30:0]  req_value,
   input  logic signed [15:0]  req_desc_value_offset,
   input  logic [11:0]         req_desc_sentinel,
   input  logic [11:0]         req_desc_symbol_base,
   input  logic [11:0]         req_sym_address,
   input  logic [15:0]         req_sym_start,
   input  logic [16:0]         req_sym_freq,
   // Result channel
   output logic                rsp_valid,
   output logic [15:0]         rsp_put_start,
   output logic [16:0]         rsp_put_freq,
   output logic [4:0]          rsp_put_bits,
   output logic                rsp_is_bypass,
   output logic                rsp_last,
   // Control register write port
   input  logic                csr_we,
   input  logic [1:0]          csr_index,
   input  logic [6:0]          csr_wdata
);

   // Control registers
   logic [4:0] symbol_bits_ff;
   logic [4:0] bypass_bits_ff;
   logic [6:0] num_dist_ff;

   // Tables and their registered read data
   logic [DESC_W-1:0] desc_mem_ff [MAX_DISTRIBUTIONS];
   logic [SYM_W-1:0]  sym_mem_ff  [MAX_SYMBOLS];
   logic [DESC_W-1:0] desc_rd_ff;
   logic [SYM_W-1:0]  sym_rd_ff;

   // Sequencer and datapath registers
   state_type             state_ff, state_in;
   logic [30:0]           value_ff;
   logic [32:0]           v_ff, v_in;
   logic [FREQ_WIDTH-1:0] bv_ff, bv_in;
   logic [FREQ_WIDTH-1:0] tmp_ff, tmp_in;
   logic [4:0]            cnt_ff, cnt_in;
   logic [POS_W-1:0]      pos_ff, pos_in;
   logic [4:0]            rem_ff, rem_in;
   logic [2:0]            pre_ff, pre_in;

   // Combinational signals
   logic              accept;
   logic              enc_go;
   logic              desc_we;
   logic              sym_we;
   logic              sym_rd_en;
   logic [4:0]        sb_sat;
   logic [4:0]        bb_sat;
   logic [DIGIT_W-1:0] maxv;
   logic [6:0]        nd_sat;
   logic [6:0]        nd_m1;
   logic [DESC_AW-1:0] desc_rd_addr;
   logic [15:0]       desc_offset;
   logic [11:0]       desc_sentinel;
   logic [11:0]       desc_base;
   logic [32:0]       diff;
   logic              in_range;
   logic [FREQ_WIDTH-1:0] bv_calc;
   logic [SYM_AW-1:0] sym_rd_addr;
   shift_req_type     shift_req;
   logic [FREQ_WIDTH-1:0] shift_result;
   logic [DIGIT_W-1:0] shift_digit;

   // Request handshake and table write strobes.
   assign busy    = (state_ff != ST_IDLE);
   assign accept  = start && !busy;
   assign enc_go  = accept && (req_action == ACT_ENCODE) && !req_dist_index[6];
   assign desc_we = accept && (req_action == ACT_LOAD_DESC) && !req_dist_index[6];
   assign sym_we  = accept && (req_action == ACT_LOAD_SYM);

   // Register saturation and the all-ones digit.
   always_comb begin
      if (symbol_bits_ff < 5'd2) begin
         sb_sat = 5'd2;
      end else if (symbol_bits_ff > 5'd16) begin
         sb_sat = 5'd16;
      end else begin
         sb_sat = symbol_bits_ff;
      end
      if (bypass_bits_ff < 5'd2) begin
         bb_sat = 5'd2;
      end else if (bypass_bits_ff > 5'd16) begin
         bb_sat = 5'd16;
      end else begin
         bb_sat = bypass_bits_ff;
      end
      maxv = DIGIT_W'((17'd1 << bb_sat) - 17'd1);
      if (num_dist_ff < 7'd1) begin
         nd_sat = 7'd1;
      end else if (num_dist_ff > 7'(MAX_DISTRIBUTIONS)) begin
         nd_sat = 7'(MAX_DISTRIBUTIONS);
      end else begin
         nd_sat = num_dist_ff;
      end
      nd_m1 = nd_sat - 7'd1;
   end

   // Clamp the distribution index to the last distribution set by num_distributions.
   always_comb begin
      if (7'(req_dist_index) > nd_m1) begin
         desc_rd_addr = nd_m1[DESC_AW-1:0];
      end else begin
         desc_rd_addr = req_dist_index[DESC_AW-1:0];
      end
   end

   // Descriptor fields.
   assign desc_offset   = desc_rd_ff[39:24];
   assign desc_sentinel = desc_rd_ff[23:12];
   assign desc_base     = desc_rd_ff[11:0];

   // Range check, zigzag mapping of the offset value and the symbol table address.
   always_comb begin
      diff     = v_ff - {21'd0, desc_sentinel};
      in_range = !v_ff[32] && diff[32];
      if (v_ff[32]) begin
         bv_calc = ~{v_ff[30:0], 1'b0};
      end else begin
         bv_calc = {diff[30:0], 1'b0};
      end
      if (in_range) begin
         sym_rd_addr = desc_base + v_ff[SYM_AW-1:0];
      end else begin
         sym_rd_addr = desc_base + desc_sentinel;
      end
   end

   // Shared shift unit.
   rsm_shifter u_shifter (
      .shift_req    (shift_req),
      .shift_result (shift_result),
      .shift_digit  (shift_digit)
   );

   // Sequencer: next state, datapath updates and put outputs.
   always_comb begin
      state_in      = state_ff;
      v_in          = v_ff;
      bv_in         = bv_ff;
      tmp_in        = tmp_ff;
      cnt_in        = cnt_ff;
      pos_in        = pos_ff;
      rem_in        = rem_ff;
      pre_in        = pre_ff;
      sym_rd_en     = 1'b0;
      shift_req     = '{data: tmp_ff, amount: SHAMT_W'(bb_sat), mask: maxv};
      rsp_valid     = 1'b0;
      rsp_put_start = 16'd0;
      rsp_put_freq  = 17'd1;
      rsp_put_bits  = bb_sat;
      rsp_is_bypass = 1'b1;
      rsp_last      = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (enc_go) begin
               state_in = ST_CALC;
            end
         end
         ST_CALC: begin
            v_in     = {{2{value_ff[30]}}, value_ff} + {{17{desc_offset[15]}}, desc_offset};
            state_in = ST_CHECK;
         end
         ST_CHECK: begin
            sym_rd_en = 1'b1;
            bv_in     = bv_calc;
            tmp_in    = bv_calc;
            cnt_in    = 5'd0;
            pos_in    = '0;
            rem_in    = 5'd0;
            pre_in    = 3'd0;
            state_in  = in_range ? ST_SYM : ST_COUNT;
         end
         ST_COUNT: begin
            // Count digits and split the count into remainder and prefix run.
            if (tmp_ff == '0) begin
               state_in = (cnt_ff == 5'd0) ? ST_REM : ST_DIGIT;
            end else begin
               tmp_in = shift_result;
               cnt_in = cnt_ff + 5'd1;
               pos_in = pos_ff + POS_W'(bb_sat);
               if (DIGIT_W'(rem_ff) + 16'd1 == maxv) begin
                  rem_in = 5'd0;
                  pre_in = pre_ff + 3'd1;
               end else begin
                  rem_in = rem_ff + 5'd1;
               end
            end
         end
         ST_DIGIT: begin
            // Most significant digit first.
            shift_req     = '{data: bv_ff, amount: SHAMT_W'(pos_ff - POS_W'(bb_sat)),
                              mask: maxv};
            rsp_valid     = 1'b1;
            rsp_put_start = shift_digit;
            pos_in        = pos_ff - POS_W'(bb_sat);
            cnt_in        = cnt_ff - 5'd1;
            if (cnt_ff == 5'd1) begin
               state_in = ST_REM;
            end
         end
         ST_REM: begin
            rsp_valid     = 1'b1;
            rsp_put_start = {11'd0, rem_ff};
            state_in      = (pre_ff == 3'd0) ? ST_SYM : ST_PREFIX;
         end
         ST_PREFIX: begin
            rsp_valid     = 1'b1;
            rsp_put_start = maxv;
            pre_in        = pre_ff - 3'd1;
            if (pre_ff == 3'd1) begin
               state_in = ST_SYM;
            end
         end
         ST_SYM: begin
            rsp_valid     = 1'b1;
            rsp_put_start = sym_rd_ff[32:17];
            rsp_put_freq  = sym_rd_ff[16:0];
            rsp_put_bits  = sb_sat;
            rsp_is_bypass = 1'b0;
            rsp_last      = 1'b1;
            state_in      = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Sequencer state and control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         symbol_bits_ff <= 5'd16;
         bypass_bits_ff <= 5'd2;
         num_dist_ff    <= 7'd1;
      end else begin
         state_ff <= state_in;
         if (csr_we) begin
            priority case (csr_index)
               CSR_SYMBOL_BITS: symbol_bits_ff <= csr_wdata[4:0];
               CSR_BYPASS_BITS: bypass_bits_ff <= csr_wdata[4:0];
               CSR_NUM_DIST:    num_dist_ff    <= csr_wdata;
               default: begin
               end
            endcase
         end
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      if (enc_go) begin
         value_ff <= req_value[30:0];
      end
      v_ff   <= v_in;
      bv_ff  <= bv_in;
      tmp_ff <= tmp_in;
      cnt_ff <= cnt_in;
      pos_ff <= pos_in;
      rem_ff <= rem_in;
      pre_ff <= pre_in;
   end

   // Descriptor table: written by loads, read once per encode request.
   always_ff @(posedge clock) begin
      if (desc_we) begin
         desc_mem_ff[req_dist_index[DESC_AW-1:0]] <=
            {req_desc_value_offset[15:0], req_desc_sentinel, req_desc_symbol_base};
      end
      if (enc_go) begin
         desc_rd_ff <= desc_mem_ff[desc_rd_addr];
      end
   end

   // Symbol table: written by loads, read once per encode request.
   always_ff @(posedge clock) begin
      if (sym_we) begin
         sym_mem_ff[req_sym_address[SYM_AW-1:0]] <= {req_sym_start, req_sym_freq};
      end
      if (sym_rd_en) begin
         sym_rd_ff <= sym_mem_ff[sym_rd_addr];
      end
   end

   // Checks on the sequencer.
   a_put_only_when_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy)
      else $error("put issued while idle");

   a_bypass_followed: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_is_bypass |=> rsp_valid)
      else $error("bypass put not followed by another put");

   a_table_put_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_is_bypass |-> rsp_last)
      else $error("table symbol put not marked last");

   a_last_frees_block: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last |=> !busy)
      else $error("block still busy after final put");

   a_encode_sets_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy && (req_action == ACT_ENCODE) && !req_dist_index[6] |=> busy)
      else $error("encode request did not start the sequencer");

endmodule

`default_nettype wire
